@@ rtl/core/fwir_pkg.sv @@
// Shared types and constants of the fixed-width integer field reader.
package fwir_pkg;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_EOF = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam int         PADDR_BITS  = 3;
    localparam logic [0:0] REG_BLANK_AS_ZERO = 1'b0;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_SEP,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] character;
        logic       field_start;
        logic [7:0] field_width;
        logic       octal_radix;
        logic [1:0] size_code;
        logic       input_exhausted;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       start;
        logic [7:0] width;
        logic       octal;
        logic [1:0] size;
        logic       exhausted;
    } t_qent;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;

endpackage

@@ rtl/core/fixed_width_integer_field_reader_core.sv @@
// Top level of the fixed-width integer field reader: register port and channels.
//
//   channel   handshake                 payload
//   in        i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   out       o_out_valid / i_out_ready o_out_item (t_out_item)
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; the back end's accumulate step sets that rate.
// An accepted item is written into the queue first and reaches the result register when it is popped.
// Input stalls only when the two-entry queue is full; output stalls back up into it.
// Synchronous active-low reset empties the queue and closes any open field.
module fixed_width_integer_field_reader_core
    import fwir_pkg::*;
#(
    parameter int ACC_BITS = 32
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic  r_blank_as_zero;
    t_qent front_ent;
    t_qent q_ent;
    logic  q_full;
    logic  q_valid;
    t_qctl q_ctl;
    logic  push;
    logic  reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_BLANK_AS_ZERO);
    assign prdata  = reg_hit ? {31'd0, r_blank_as_zero} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_as_zero <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_blank_as_zero <= pwdata[0];
        end
    end

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    fwir_front u_front (
        .i_item (i_in_item),
        .o_ent  (front_ent)
    );

    fwir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (front_ent),
        .o_full  (q_full),
        .i_ctl   (q_ctl),
        .o_ent   (q_ent),
        .o_valid (q_valid)
    );

    fwir_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_blank_as_zero (r_blank_as_zero),
        .i_ent           (q_ent),
        .i_valid         (q_valid),
        .o_ctl           (q_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item)
    );

endmodule

@@ rtl/core/fwir_front.sv @@
// Front end: classifies each incoming character into a queue entry.
module fwir_front
    import fwir_pkg::*;
(
    input  t_in_item i_item,
    output t_qent    o_ent
);

    t_cls cls;

    always_comb begin
        if (i_item.character inside {[CH_ZERO:CH_NINE]}) begin
            cls = CLS_DIGIT;
        end else if (i_item.character == CH_BLANK) begin
            cls = CLS_BLANK;
        end else if (i_item.character == CH_PLUS) begin
            cls = CLS_PLUS;
        end else if (i_item.character == CH_MINUS) begin
            cls = CLS_MINUS;
        end else if (i_item.character inside {CH_COMMA, CH_NEWLINE}) begin
            cls = CLS_SEP;
        end else begin
            cls = CLS_OTHER;
        end
    end

    always_comb begin
        o_ent.cls       = cls;
        o_ent.digit     = 4'(i_item.character - CH_ZERO);
        o_ent.start     = i_item.field_start;
        o_ent.width     = i_item.field_width;
        o_ent.octal     = i_item.octal_radix;
        o_ent.size      = i_item.size_code;
        o_ent.exhausted = i_item.input_exhausted;
    end

endmodule

@@ rtl/core/fwir_queue.sv @@
// Short queue of classified items between front and back.
module fwir_queue
    import fwir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_full,
    input  t_qctl i_ctl,
    output t_qent o_ent,
    output logic  o_valid
);

    t_qent                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wptr;
    logic [Q_PTR_BITS-1:0] r_rptr;
    logic [Q_PTR_BITS:0]   r_count;
    logic [Q_PTR_BITS-1:0] n_wptr;
    logic [Q_PTR_BITS-1:0] n_rptr;
    logic [Q_PTR_BITS:0]   n_count;
    logic                  pop;

    assign o_full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rptr];
    assign pop     = i_ctl.valid && i_ctl.pop;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_ent;
        end
    end

endmodule

@@ rtl/core/fwir_back.sv @@
// Back end: field state, digit accumulation and the result register.
module fwir_back
    import fwir_pkg::*;
#(
    parameter int ACC_BITS = 32
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_blank_as_zero,
    input  t_qent     i_ent,
    input  logic      i_valid,
    output t_qctl     o_ctl,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int EXT_BITS = (ACC_BITS > 32) ? ACC_BITS : 32;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [ACC_BITS-1:0] r_acc;
    logic [ACC_BITS-1:0] n_acc;
    logic                r_neg;
    logic                n_neg;
    logic [7:0]          r_left;
    logic [7:0]          n_left;
    logic                r_octal;
    logic                n_octal;
    logic [1:0]          r_size;
    logic [1:0]          n_size;
    logic                r_bad;
    logic                n_bad;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                pop;
    logic                zero_width;
    t_phase              e_phase;
    logic [ACC_BITS-1:0] e_acc;
    logic                e_neg;
    logic [7:0]          e_left;
    logic                e_octal;
    logic [1:0]          e_size;
    logic                e_bad;
    logic [ACC_BITS-1:0] acc_scaled;
    logic [ACC_BITS-1:0] t_acc;
    logic                t_neg;
    logic                t_bad;
    t_phase              t_phase_v;
    logic [7:0]          t_left;
    logic [ACC_BITS-1:0] f_acc;
    logic                f_neg;
    logic                f_bad;
    logic [EXT_BITS-1:0] acc_ext;
    logic [31:0]         w_low;
    logic [31:0]         w_signed;
    logic [31:0]         w_cut;
    logic                emit;
    t_out_item           emit_item;

    assign pop         = i_valid && (!r_out_valid || i_out_ready);
    assign o_ctl.valid = i_valid;
    assign o_ctl.pop   = pop;

    assign zero_width = i_ent.start && (i_ent.width == 8'd0);
    assign e_phase    = i_ent.start ? PH_LEAD : r_phase;
    assign e_acc      = i_ent.start ? '0 : r_acc;
    assign e_neg      = i_ent.start ? 1'b0 : r_neg;
    assign e_bad      = i_ent.start ? 1'b0 : r_bad;
    assign e_left     = i_ent.start ? i_ent.width : r_left;
    assign e_octal    = i_ent.start ? i_ent.octal : r_octal;
    assign e_size     = i_ent.start ? i_ent.size : r_size;

    assign acc_scaled = e_octal ? (e_acc << 3) : ((e_acc << 3) + (e_acc << 1));
    assign t_left     = e_left - 8'd1;

    always_comb begin
        t_acc     = e_acc;
        t_neg     = e_neg;
        t_bad     = e_bad;
        t_phase_v = e_phase;
        if (!e_bad) begin
            case (i_ent.cls)
                CLS_DIGIT: begin
                    t_acc     = acc_scaled + ACC_BITS'(i_ent.digit);
                    t_phase_v = PH_BODY;
                end
                CLS_BLANK: begin
                    if (e_phase == PH_BODY && i_blank_as_zero) begin
                        t_acc = acc_scaled;
                    end
                end
                CLS_PLUS, CLS_MINUS: begin
                    if (e_phase == PH_LEAD) begin
                        t_neg     = (i_ent.cls == CLS_MINUS);
                        t_phase_v = PH_BODY;
                    end else begin
                        t_bad = 1'b1;
                    end
                end
                default: begin
                    t_bad = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        if (zero_width) begin
            n_phase = PH_IDLE;
        end else if (e_phase == PH_IDLE || i_ent.exhausted || i_ent.cls == CLS_SEP) begin
            n_phase = PH_IDLE;
        end else if (t_left == 8'd0) begin
            n_phase = PH_IDLE;
        end else begin
            n_phase = t_phase_v;
        end
    end

    assign f_acc    = (i_ent.cls == CLS_SEP) ? e_acc : t_acc;
    assign f_neg    = (i_ent.cls == CLS_SEP) ? e_neg : t_neg;
    assign f_bad    = (i_ent.cls == CLS_SEP) ? e_bad : t_bad;
    assign acc_ext  = EXT_BITS'(signed'(f_acc));
    assign w_low    = acc_ext[31:0];
    assign w_signed = f_neg ? (~w_low + 32'd1) : w_low;

    always_comb begin
        case (e_size)
            SZ_BYTE: w_cut = {{24{w_signed[7]}}, w_signed[7:0]};
            SZ_HALF: w_cut = {{16{w_signed[15]}}, w_signed[15:0]};
            default: w_cut = w_signed;
        endcase
    end

    always_comb begin
        n_acc           = r_acc;
        n_neg           = r_neg;
        n_bad           = r_bad;
        n_left          = r_left;
        n_octal         = e_octal;
        n_size          = e_size;
        emit            = 1'b0;
        emit_item.value = '0;
        emit_item.status = ST_OK;
        if (zero_width) begin
            n_left = e_left;
            emit   = 1'b1;
        end else if (e_phase == PH_IDLE) begin
            n_left = e_left;
        end else if (i_ent.exhausted) begin
            n_acc            = e_acc;
            n_neg            = e_neg;
            n_bad            = e_bad;
            n_left           = e_left;
            emit             = 1'b1;
            emit_item.status = ST_EOF;
        end else begin
            n_acc  = (i_ent.cls == CLS_SEP) ? e_acc : t_acc;
            n_neg  = f_neg;
            n_bad  = f_bad;
            n_left = (i_ent.cls == CLS_SEP) ? e_left : t_left;
            if (i_ent.cls == CLS_SEP || t_left == 8'd0) begin
                emit             = 1'b1;
                emit_item.value  = signed'(w_cut);
                emit_item.status = f_bad ? ST_BAD : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_left      <= '0;
            r_octal     <= 1'b0;
            r_size      <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_left  <= n_left;
                r_octal <= n_octal;
                r_size  <= n_size;
                r_bad   <= n_bad;
            end
            if (pop) begin
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out_item <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ test/tb_fixed_width_integer_field_reader_core.sv @@
// Testbench for the fixed-width integer field reader: directed and random fields, scoreboard checks.
module tb_fixed_width_integer_field_reader_core;
    import fwir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class field_scoreboard;
        bit          blank_zero;
        t_phase      ph;
        logic [31:0] acc;
        bit          neg;
        bit          bad;
        bit          octal;
        logic [7:0]  left;
        logic [1:0]  size;
        t_out_item   pending_fields[$];
        int          errors;

        function new();
            blank_zero = 1'b0;
            ph         = PH_IDLE;
            acc        = '0;
            neg        = 1'b0;
            bad        = 1'b0;
            octal      = 1'b0;
            left       = '0;
            size       = '0;
            errors     = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
            errors++;
        endtask

        function void push_result(logic [31:0] v, logic [1:0] st);
            t_out_item r;
            r.value  = v;
            r.status = st;
            pending_fields.push_back(r);
            ph = PH_IDLE;
        endfunction

        function void close_field();
            logic [31:0] v;
            v = neg ? (32'd0 - acc) : acc;
            case (size)
                SZ_BYTE: v = {{24{v[7]}}, v[7:0]};
                SZ_HALF: v = {{16{v[15]}}, v[15:0]};
                default: ;
            endcase
            push_result(v, bad ? ST_BAD : ST_OK);
        endfunction

        function void take_char(logic [7:0] c);
            logic [31:0] r;
            r = octal ? 32'd8 : 32'd10;
            if (bad)
                return;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                acc = acc * r + 32'(c - CH_ZERO);
                ph  = PH_BODY;
            end else if (c == CH_BLANK) begin
                if (ph == PH_BODY && blank_zero)
                    acc = acc * r;
            end else if (ph == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                neg = (c == CH_MINUS);
                ph  = PH_BODY;
            end else begin
                bad = 1'b1;
            end
        endfunction

        function void note_item(t_in_item it);
            if (it.field_start) begin
                acc   = '0;
                neg   = 1'b0;
                bad   = 1'b0;
                octal = it.octal_radix;
                size  = it.size_code;
                left  = it.field_width;
                if (it.field_width == 8'd0) begin
                    push_result('0, ST_OK);
                    return;
                end
                ph = PH_LEAD;
            end
            if (ph == PH_IDLE)
                return;
            if (it.input_exhausted) begin
                push_result('0, ST_EOF);
                return;
            end
            if (it.character == CH_COMMA || it.character == CH_NEWLINE) begin
                close_field();
                return;
            end
            take_char(it.character);
            left = left - 8'd1;
            if (left == 8'd0)
                close_field();
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_fields.size() == 0) begin
                report_mismatch("unexpected result value", got.value, '0);
                return;
            end
            want = pending_fields.pop_front();
            if (got.value !== want.value)
                report_mismatch("value", got.value, want.value);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_item     = '0;
    logic                  out_ready   = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_BITS-1:0] paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic [31:0]           prdata;
    logic                  pready;

    field_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    bit hold_req      = 1'b0;

    localparam logic [PADDR_BITS-1:0] ADDR_BLANK = {REG_BLANK_AS_ZERO, 2'b00};

    fixed_width_integer_field_reader_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("** fixed_width_integer_field_reader_core: FAILED **");
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            sb.check_result(o_out_item);
    end

    function automatic t_in_item mk_item(logic [7:0] c, logic start, logic [7:0] w,
                                         logic oct, logic [1:0] sz, logic exh);
        t_in_item it;
        it.character       = c;
        it.field_start     = start;
        it.field_width     = w;
        it.octal_radix     = oct;
        it.size_code       = sz;
        it.input_exhausted = exh;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic [7:0] w, input logic oct,
                             input logic [1:0] sz);
        for (int k = 0; k < s.len(); k++)
            send_item(mk_item(s[k], k == 0, w, oct, sz, 1'b0));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_BITS-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic read_reg(input logic [PADDR_BITS-1:0] a, output logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        d = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_blank_zero(input bit v);
        logic [31:0] rd;
        write_reg(ADDR_BLANK, {31'd0, v});
        sb.blank_zero = v;
        read_reg(ADDR_BLANK, rd);
        if (rd !== {31'd0, v})
            sb.report_mismatch("blank_as_zero readback", rd, {31'd0, v});
    endtask

    task automatic send_random_field();
        t_in_item it;
        int       w;
        int       nlead;
        int       r;
        bit       has_sign;
        logic     oct;
        logic [1:0] sz;
        if ($urandom_range(29) == 0)
            w = 0;
        else if ($urandom_range(39) == 0)
            w = $urandom_range(255);
        else
            w = $urandom_range(1, 11);
        oct      = 1'($urandom_range(1));
        sz       = 2'($urandom_range(3));
        nlead    = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
        has_sign = 1'($urandom_range(1));
        send_item(mk_item(8'($urandom_range(255)), 1'b1, 8'(w), oct, sz, 1'b0));
        if (w == 0)
            return;
        for (int k = 1; k < w; k++) begin
            it = mk_item(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                         1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0);
            r = $urandom_range(99);
            if (k <= nlead)
                it.character = CH_BLANK;
            else if (k == nlead + 1 && has_sign)
                it.character = $urandom_range(1) ? CH_MINUS : CH_PLUS;
            else if (r < 70)
                it.character = CH_ZERO + 8'($urandom_range(9));
            else if (r < 84)
                it.character = CH_BLANK;
            else if (r < 87)
                it.character = $urandom_range(1) ? CH_COMMA : CH_NEWLINE;
            else if (r < 89)
                it.input_exhausted = 1'b1;
            else if (r < 91)
                return;
            else if (r < 94)
                it.character = $urandom_range(1) ? CH_PLUS : CH_MINUS;
            else if (r >= 97)
                it.character = CH_ZERO + 8'($urandom_range(9));
            send_item(it);
            if (it.input_exhausted || it.character == CH_COMMA || it.character == CH_NEWLINE)
                return;
        end
    endtask

    task automatic send_noise();
        t_in_item it;
        repeat ($urandom_range(1, 3)) begin
            it                 = t_in_item'($urandom());
            it.field_start     = ($urandom_range(3) == 0);
            it.input_exhausted = ($urandom_range(7) == 0);
            send_item(it);
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 88)
                send_random_field();
            else
                send_noise();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_blank_zero(1'b0);

        send_item(mk_item("5", 1'b1, 8'd0, 1'b0, 2'd0, 1'b0));
        send_item(mk_item("7", 1'b0, 8'd3, 1'b0, 2'd0, 1'b0));
        send_text("  ,", 8'd3, 1'b0, SZ_BYTE);
        send_text("-7 9", 8'd4, 1'b1, SZ_HALF);
        send_text("1+2", 8'd3, 1'b0, 2'd3);
        send_item(mk_item(8'h00, 1'b1, 8'd2, 1'b0, SZ_BYTE, 1'b0));
        send_item(mk_item("1", 1'b0, 8'd2, 1'b0, SZ_BYTE, 1'b0));
        send_text("12", 8'd5, 1'b0, 2'd2);
        send_item(mk_item(8'hFF, 1'b0, 8'hFF, 1'b1, 2'd3, 1'b1));
        send_text("9", 8'd4, 1'b0, 2'd2);
        send_text("8", 8'd1, 1'b1, SZ_BYTE);
        send_text("3\n", 8'd5, 1'b0, 2'd2);
        send_text("--", 8'd2, 1'b0, 2'd2);
        send_text("-2147483648", 8'd11, 1'b0, 2'd2);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_blank_zero(p == 1 || p == 2);
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            run_random(110);
            drain();
        end

        set_blank_zero(1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        run_random(60);
        drain();

        if (sb.errors == 0)
            $display("** fixed_width_integer_field_reader_core: PASSED **");
        else
            $display("** fixed_width_integer_field_reader_core: FAILED **");
        $finish;
    end

endmodule
